@@ rtl/core/counting_semaphore_bank_core_assert.svh @@
`ifndef COUNTING_SEMAPHORE_BANK_CORE_ASSERT_SVH
`define COUNTING_SEMAPHORE_BANK_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CSB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CSB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/csb_pkg.sv @@
package csb_pkg;

	localparam int THREAD_COUNT = 256;
	localparam logic signed [15:0] COUNT_MAX = 16'sh7fff;

	typedef enum logic [1:0] {
		OP_INIT    = 2'd0,
		OP_WAIT    = 2'd1,
		OP_POST    = 2'd2,
		OP_DESTROY = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_BLOCKED = 3'd1,
		ST_INVALID = 3'd2,
		ST_WAITERS = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef struct packed {
		status_t            status;
		logic               rel_valid;
		logic [7:0]         rel_thread;
		logic signed [15:0] count;
	} res_t;

endpackage

@@ rtl/core/csb_ram.sv @@
module csb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/core/csb_exec.sv @@
module csb_exec import csb_pkg::*; #(
	parameter int NUM_SEMS = 16,
	parameter int QUEUE_DEPTH = 8,
	localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int LEN_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic [1:0]         op,
	input  logic [3:0]         sem_index,
	input  logic [7:0]         thread_id,
	input  logic signed [15:0] init_value,
	input  logic               in_use,
	input  logic signed [15:0] count,
	input  logic [HEAD_W-1:0]  head,
	input  logic [LEN_W-1:0]   len,
	input  logic [7:0]         slot,
	output res_t               res,
	output logic               upd,
	output logic               nx_in_use,
	output logic signed [15:0] nx_count,
	output logic [HEAD_W-1:0]  nx_head,
	output logic [LEN_W-1:0]   nx_len,
	output logic               slot_we,
	output logic [HEAD_W-1:0]  slot_pos
);

	logic               idx_ok;
	logic               tid_ok;
	logic               full;
	logic [LEN_W:0]     tail_sum;
	logic [LEN_W:0]     tail_pos;
	logic [HEAD_W-1:0]  head_inc;

	assign idx_ok = 32'(sem_index) < NUM_SEMS;
	assign tid_ok = 32'(thread_id) < THREAD_COUNT;
	assign full = 32'(len) >= QUEUE_DEPTH;
	assign tail_sum = (LEN_W + 1)'(head) + (LEN_W + 1)'(len);
	assign tail_pos = (32'(tail_sum) >= QUEUE_DEPTH) ?
		tail_sum - (LEN_W + 1)'(QUEUE_DEPTH) : tail_sum;
	assign head_inc = (32'(head) == QUEUE_DEPTH - 1) ? '0 : head + HEAD_W'(1);
	assign slot_pos = HEAD_W'(tail_pos);

	always_comb begin
		res.status = ST_OK;
		res.rel_valid = 1'b0;
		res.rel_thread = '0;
		res.count = '0;
		upd = 1'b0;
		slot_we = 1'b0;
		nx_in_use = in_use;
		nx_count = count;
		nx_head = head;
		nx_len = len;
		if (!idx_ok) begin
			res.status = ST_INVALID;
		end else if (op_t'(op) == OP_INIT) begin
			upd = 1'b1;
			nx_in_use = 1'b1;
			nx_count = init_value;
			nx_head = '0;
			nx_len = '0;
			res.count = init_value;
		end else if (!in_use) begin
			res.status = ST_INVALID;
		end else begin
			case (op_t'(op))
				OP_WAIT: begin
					if (!tid_ok) begin
						res.status = ST_INVALID;
					end else if (count > 16'sd0) begin
						upd = 1'b1;
						nx_count = count - 16'sd1;
						res.count = count - 16'sd1;
					end else if (full) begin
						res.status = ST_FULL;
						res.count = count;
					end else begin
						upd = 1'b1;
						slot_we = 1'b1;
						nx_len = len + LEN_W'(1);
						res.status = ST_BLOCKED;
						res.count = count;
					end
				end
				OP_POST: begin
					upd = 1'b1;
					res.count = count;
					if (len != '0 && count >= 16'sd0) begin
						res.rel_valid = 1'b1;
						res.rel_thread = slot;
						nx_head = head_inc;
						nx_len = len - LEN_W'(1);
					end else if (count != COUNT_MAX) begin
						nx_count = count + 16'sd1;
						res.count = count + 16'sd1;
					end
				end
				OP_DESTROY: begin
					if (len != '0) begin
						res.status = ST_WAITERS;
						res.count = count;
					end else begin
						upd = 1'b1;
						nx_in_use = 1'b0;
						nx_count = '0;
						nx_head = '0;
					end
				end
				default: begin
					res.status = ST_INVALID;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/counting_semaphore_bank_core.sv @@
// Path: an accepted request passes the request register, then the result register;
// a stalled result side holds it in place. Throughput: one request per cycle
// unless the result side stalls; state and queue slot write back as the request
// leaves the request register, so the next one sees them at once.
// Reset: all semaphores invalid with zero count and empty queue; queue slots
// are not cleared and need no clearing pass.
module counting_semaphore_bank_core import csb_pkg::*; #(
	parameter int NUM_SEMS = 16,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [3:0]         sem_index,
	input  logic [7:0]         thread_id,
	input  logic signed [15:0] init_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic               released_valid,
	output logic [7:0]         released_thread,
	output logic signed [15:0] count_after
);

	`include "counting_semaphore_bank_core_assert.svh"

	localparam int SEM_W = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
	localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LEN_W = $clog2(QUEUE_DEPTH + 1);
	localparam int SLOTS = NUM_SEMS * QUEUE_DEPTH;
	localparam int ADDR_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	logic [NUM_SEMS-1:0] in_use_q;
	logic signed [15:0]  count_q [NUM_SEMS];
	logic [HEAD_W-1:0]   head_q [NUM_SEMS];
	logic [LEN_W-1:0]    len_q [NUM_SEMS];

	logic               v_s1;
	logic [1:0]         op_s1;
	logic [3:0]         sem_s1;
	logic [7:0]         tid_s1;
	logic signed [15:0] ival_s1;
	logic               byp_s1;
	logic [7:0]         bypd_s1;

	logic out_v_q;
	res_t res_q;

	logic               adv;
	logic               acc;
	logic [SEM_W-1:0]   sidx_s1;
	logic [SEM_W-1:0]   sidx_in;
	logic [HEAD_W-1:0]  head_fwd;
	logic [ADDR_W-1:0]  raddr;
	logic [ADDR_W-1:0]  waddr;
	logic               wr_en;
	logic [7:0]         rdata;
	logic [7:0]         slot;

	res_t               res;
	logic               upd;
	logic               nx_in_use;
	logic signed [15:0] nx_count;
	logic [HEAD_W-1:0]  nx_head;
	logic [LEN_W-1:0]   nx_len;
	logic               slot_we;
	logic [HEAD_W-1:0]  slot_pos;

	assign adv = v_s1 && (!out_v_q || out_ready);
	assign in_ready = !v_s1 || adv;
	assign acc = in_valid && in_ready;

	assign sidx_s1 = SEM_W'(sem_s1);
	assign sidx_in = SEM_W'(sem_index);

	// forward the head of a request leaving this cycle to the slot read
	assign head_fwd = (adv && upd && sidx_s1 == sidx_in) ? nx_head : head_q[sidx_in];
	assign raddr = ADDR_W'(32'(sidx_in) * QUEUE_DEPTH + 32'(head_fwd));
	assign waddr = ADDR_W'(32'(sidx_s1) * QUEUE_DEPTH + 32'(slot_pos));
	assign wr_en = adv && slot_we;
	assign slot = byp_s1 ? bypd_s1 : rdata;

	csb_ram #(
		.WIDTH(8),
		.DEPTH(SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata(tid_s1),
		.re   (acc),
		.raddr(raddr),
		.rdata(rdata)
	);

	csb_exec #(
		.NUM_SEMS(NUM_SEMS),
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_exec (
		.op        (op_s1),
		.sem_index (sem_s1),
		.thread_id (tid_s1),
		.init_value(ival_s1),
		.in_use    (in_use_q[sidx_s1]),
		.count     (count_q[sidx_s1]),
		.head      (head_q[sidx_s1]),
		.len       (len_q[sidx_s1]),
		.slot      (slot),
		.res       (res),
		.upd       (upd),
		.nx_in_use (nx_in_use),
		.nx_count  (nx_count),
		.nx_head   (nx_head),
		.nx_len    (nx_len),
		.slot_we   (slot_we),
		.slot_pos  (slot_pos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= '0;
			for (int i = 0; i < NUM_SEMS; i++) begin
				count_q[i] <= '0;
				head_q[i] <= '0;
				len_q[i] <= '0;
			end
		end else if (adv && upd) begin
			in_use_q[sidx_s1] <= nx_in_use;
			count_q[sidx_s1] <= nx_count;
			head_q[sidx_s1] <= nx_head;
			len_q[sidx_s1] <= nx_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (acc) begin
			v_s1 <= 1'b1;
		end else if (adv) begin
			v_s1 <= 1'b0;
		end
	end

	// hold the request while the result side stalls
	always_ff @(posedge clk) begin
		if (acc) begin
			op_s1 <= operation;
			sem_s1 <= sem_index;
			tid_s1 <= thread_id;
			ival_s1 <= init_value;
			byp_s1 <= wr_en && waddr == raddr;
			bypd_s1 <= tid_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign status = res_q.status;
	assign released_valid = res_q.rel_valid;
	assign released_thread = res_q.rel_thread;
	assign count_after = res_q.count;

	`CSB_ASSERT_NOW(a_rel_ok, out_v_q && res_q.rel_valid, res_q.status == ST_OK, "release with bad status")
	`CSB_ASSERT_NOW(a_wr_blocked, wr_en, res.status == ST_BLOCKED, "slot write without a blocked wait")
	`CSB_ASSERT_NEXT(a_acc_s1, acc, v_s1, "accepted request lost")
	`CSB_ASSERT_NEXT(a_adv_out, adv, out_v_q, "result not registered")

endmodule
